// ----- rtl/set_assoc_cache_lru_sim_core_macros.svh -----
// Assertion macros shared by the cache simulator RTL.
`ifndef SET_ASSOC_CACHE_LRU_SIM_CORE_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_SIM_CORE_MACROS_SVH

// Clocked check, masked while reset is high.
`define SACL_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also runs during reset.
`define SACL_CHECK_RESET(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/sacl_pkg.sv -----
package sacl_pkg;

   // Default geometry
   localparam int MAX_SET_BITS_DEF = 6;
   localparam int MAX_WAYS_DEF     = 8;

   // Fixed field widths
   localparam int ADDR_W     = 32;
   localparam int TAG_W      = 32;
   localparam int COUNT_W    = 32;
   localparam int KIND_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   // Access kinds (kind 3 behaves as a load)
   localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_STORE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_IN_USE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BITS  = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // latch the item, start the set read
      logic commit;    // update the set, load the result register
   } dp_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] req_type;
      logic [ADDR_W-1:0] address;
   } req_item_type;

   typedef struct packed {
      logic [1:0]         hit_count;
      logic               missed;
      logic               evicted;
      logic [COUNT_W-1:0] total_hits;
      logic [COUNT_W-1:0] total_misses;
      logic [COUNT_W-1:0] total_evictions;
   } rsp_item_type;

endpackage

// ----- rtl/sacl_ram.sv -----
module sacl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/sacl_ctrl.sv -----
`include "set_assoc_cache_lru_sim_core_macros.svh"

module sacl_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sacl_pkg::dp_cmd_type cmd
);

   sacl_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   // Result register can take a new item
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sacl_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = sacl_pkg::ST_LOOKUP;
            end
         end
         sacl_pkg::ST_LOOKUP: begin
            if (out_free) begin
               state_in = sacl_pkg::ST_IDLE;
            end
         end
         default: state_in = sacl_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         sacl_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         sacl_pkg::ST_LOOKUP: begin
            cmd.commit = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Result valid flag
   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sacl_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `SACL_ASSERT(a_one_item_at_a_time, (req_valid && req_ready) |=> !req_ready, "item accepted while busy")
   `SACL_ASSERT(a_commit_shows_result, cmd.commit |=> rsp_valid, "committed item not presented")
   `SACL_CHECK_RESET(a_reset_empties_output, reset |=> !rsp_valid, "result valid after reset")

endmodule

// ----- rtl/sacl_dp.sv -----
`include "set_assoc_cache_lru_sim_core_macros.svh"

module sacl_dp #(
   parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
   parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sacl_pkg::dp_cmd_type                cmd,
   input  sacl_pkg::req_item_type              req_data,
   input  logic                                csr_we,
   input  logic [sacl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sacl_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output sacl_pkg::rsp_item_type              rsp_data
);

   localparam int SETS      = 1 << MAX_SET_BITS;
   localparam int SET_IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int RANK_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WAY_W     = RANK_W;
   localparam int WCNT_W    = $clog2(MAX_WAYS + 1);
   localparam int TAG_W     = sacl_pkg::TAG_W;
   localparam int CNT_W     = sacl_pkg::COUNT_W;
   localparam int ENTRY_W   = TAG_W + RANK_W + 1;
   localparam int ROW_W     = MAX_WAYS * ENTRY_W;
   localparam logic [RANK_W-1:0] RANK_TOP = RANK_W'(MAX_WAYS - 1);

   // Configuration registers
   logic [2:0] set_bits_ff;
   logic [3:0] ways_ff;
   logic [4:0] block_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= 3'd0;
         ways_ff       <= 4'd1;
         block_bits_ff <= 5'd0;
      end else if (csr_we) begin
         case (csr_index)
            sacl_pkg::CSR_SET_BITS:    set_bits_ff   <= csr_wdata[2:0];
            sacl_pkg::CSR_WAYS_IN_USE: ways_ff       <= csr_wdata[3:0];
            sacl_pkg::CSR_BLOCK_BITS:  block_bits_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamped geometry
   logic [2:0]        s_eff;
   logic [WCNT_W-1:0] w_eff;

   always_comb begin
      if (int'(set_bits_ff) > MAX_SET_BITS) begin
         s_eff = 3'(MAX_SET_BITS);
      end else begin
         s_eff = set_bits_ff;
      end
      if (ways_ff == 4'd0) begin
         w_eff = WCNT_W'(1);
      end else if (int'(ways_ff) > MAX_WAYS) begin
         w_eff = WCNT_W'(MAX_WAYS);
      end else begin
         w_eff = WCNT_W'(ways_ff);
      end
   end

   // Address split of the incoming item
   logic [31:0]          shifted;
   logic [31:0]          set_full;
   logic [SET_IDX_W-1:0] set_idx;
   logic [TAG_W-1:0]     tag_new;

   assign shifted  = req_data.address >> block_bits_ff;
   assign set_full = shifted & ((32'd1 << s_eff) - 32'd1);
   assign set_idx  = set_full[SET_IDX_W-1:0];
   assign tag_new  = shifted >> s_eff;

   // Per-set valid flags: a row never written reads as all lines invalid
   logic [SETS-1:0] row_valid_ff;

   // Item capture
   logic [TAG_W-1:0]            tag_ff;
   logic [SET_IDX_W-1:0]        set_ff;
   logic [sacl_pkg::KIND_W-1:0] kind_ff;
   logic                        row_live_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         tag_ff      <= tag_new;
         set_ff      <= set_idx;
         kind_ff     <= req_data.req_type;
         row_live_ff <= row_valid_ff[set_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (cmd.commit) begin
         row_valid_ff[set_ff] <= 1'b1;
      end
   end

   // Set storage: one row holds all ways of a set
   logic [ROW_W-1:0] row_rd, row_wr;

   sacl_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SETS)
   ) u_set_ram (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (set_ff),
      .wr_data (row_wr),
      .rd_en   (cmd.capture),
      .rd_addr (set_idx),
      .rd_data (row_rd)
   );

   // Unpack the row; an unwritten row shows invalid lines of rank zero
   logic [TAG_W-1:0]  way_tag   [MAX_WAYS];
   logic [RANK_W-1:0] way_rank  [MAX_WAYS];
   logic [MAX_WAYS-1:0] way_valid;
   logic [MAX_WAYS-1:0] way_on;
   logic [TAG_W-1:0]  new_tag   [MAX_WAYS];
   logic [RANK_W-1:0] new_rank  [MAX_WAYS];
   logic [MAX_WAYS-1:0] new_valid;

   for (genvar g = 0; g < MAX_WAYS; g++) begin : g_way
      assign way_tag[g]   = row_rd[g*ENTRY_W +: TAG_W];
      assign way_rank[g]  = row_live_ff ? row_rd[g*ENTRY_W+TAG_W +: RANK_W] : '0;
      assign way_valid[g] = row_live_ff & row_rd[g*ENTRY_W+TAG_W+RANK_W];
      assign way_on[g]    = (g < int'(w_eff));
      assign row_wr[g*ENTRY_W +: ENTRY_W] = {new_valid[g], new_rank[g], new_tag[g]};
   end

   // Tag compare, fill and victim choice
   logic [MAX_WAYS-1:0] hit_vec, empty_vec;
   logic                hit, found_empty, evict;
   logic [WAY_W-1:0]    hit_way, empty_way, lru_way, target;
   logic [RANK_W-1:0]   old_rank;

   always_comb begin
      hit_way   = '0;
      empty_way = '0;
      lru_way   = '0;
      for (int i = 0; i < MAX_WAYS; i++) begin
         hit_vec[i]   = way_on[i] & way_valid[i] & (way_tag[i] == tag_ff);
         empty_vec[i] = way_on[i] & ~way_valid[i];
      end
      // lowest matching way wins
      for (int i = MAX_WAYS - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_way = WAY_W'(i);
         end
         if (empty_vec[i]) begin
            empty_way = WAY_W'(i);
         end
      end
      // first used way with the greatest rank
      for (int i = 1; i < MAX_WAYS; i++) begin
         if (way_on[i] && (way_rank[i] > way_rank[lru_way])) begin
            lru_way = WAY_W'(i);
         end
      end
      hit         = |hit_vec;
      found_empty = |empty_vec;
      evict       = !hit && !found_empty;
      old_rank    = way_rank[hit_way];
      if (hit) begin
         target = hit_way;
      end else if (found_empty) begin
         target = empty_way;
      end else begin
         target = lru_way;
      end
   end

   // Recency update of the set
   always_comb begin
      for (int i = 0; i < MAX_WAYS; i++) begin
         new_valid[i] = way_valid[i];
         new_rank[i]  = way_rank[i];
         new_tag[i]   = way_tag[i];
         if (way_on[i]) begin
            if (WAY_W'(i) == target) begin
               new_valid[i] = 1'b1;
               new_rank[i]  = '0;
               new_tag[i]   = tag_ff;
            end else if (way_valid[i] && !(hit && (way_rank[i] >= old_rank)) &&
                         (way_rank[i] < RANK_TOP)) begin
               new_rank[i] = way_rank[i] + RANK_W'(1);
            end
         end
      end
   end

   // Hit count and saturating totals
   logic [1:0]       hit_count;
   logic [CNT_W:0]   hit_sum;
   logic [CNT_W-1:0] hit_total_ff, miss_total_ff, evict_total_ff;
   logic [CNT_W-1:0] hit_total_in, miss_total_in, evict_total_in;

   assign hit_count = {1'b0, hit} +
                      ((kind_ff == sacl_pkg::KIND_MODIFY) ? 2'd1 : 2'd0);
   assign hit_sum   = {1'b0, hit_total_ff} + (CNT_W+1)'(hit_count);

   always_comb begin
      hit_total_in   = hit_sum[CNT_W] ? '1 : hit_sum[CNT_W-1:0];
      miss_total_in  = miss_total_ff;
      evict_total_in = evict_total_ff;
      if (!hit && !(&miss_total_ff)) begin
         miss_total_in = miss_total_ff + CNT_W'(1);
      end
      if (evict && !(&evict_total_ff)) begin
         evict_total_in = evict_total_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_total_ff   <= '0;
         miss_total_ff  <= '0;
         evict_total_ff <= '0;
      end else if (cmd.commit) begin
         hit_total_ff   <= hit_total_in;
         miss_total_ff  <= miss_total_in;
         evict_total_ff <= evict_total_in;
      end
   end

   // Result register
   sacl_pkg::rsp_item_type rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff.hit_count       <= hit_count;
         rsp_ff.missed          <= !hit;
         rsp_ff.evicted         <= evict;
         rsp_ff.total_hits      <= hit_total_in;
         rsp_ff.total_misses    <= miss_total_in;
         rsp_ff.total_evictions <= evict_total_in;
      end
   end

   assign rsp_data = rsp_ff;

   `SACL_ASSERT(a_row_marked_written, cmd.commit |=> row_valid_ff[$past(set_ff)], "set not marked written")
   `SACL_ASSERT(a_hits_never_drop, cmd.commit |=> (hit_total_ff >= $past(hit_total_ff)), "hit total went down")

endmodule

// ----- rtl/set_assoc_cache_lru_sim_core.sv -----
// Set-associative cache simulator with true LRU replacement. Each item is one
// access (load, store or modify) to a 32-bit byte address and yields exactly
// one result item: hits caused (a modify adds one for its write), miss and
// eviction flags, and saturating running totals. Geometry comes from three
// registers (set bits, ways in use, block offset bits) written while idle; the
// user is bound to that, as the block itself does not enforce it. For each
// item the whole set row is first read from the set RAM; then all tags are
// compared, the line is picked, the recency ranks are updated and the row is
// written back, which waits while the result register holds an untaken result.
// Items are handled one at a time. Per-set written flags are cleared by reset,
// so the block accepts items right after reset with no clearing pass.
module set_assoc_cache_lru_sim_core #(
   parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
   parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  sacl_pkg::req_item_type          req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output sacl_pkg::rsp_item_type          rsp_data,
   input  logic                            csr_we,
   input  logic [sacl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sacl_pkg::CSR_DATA_W-1:0] csr_wdata
);

   sacl_pkg::dp_cmd_type cmd;

   sacl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   sacl_dp #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- tb/sv/tb_set_assoc_cache_lru_sim_core.sv -----
module tb_set_assoc_cache_lru_sim_core;
   import sacl_pkg::*;

   localparam int MAX_SET_BITS = MAX_SET_BITS_DEF;
   localparam int MAX_WAYS     = MAX_WAYS_DEF;
   localparam int LINE_COUNT   = (1 << MAX_SET_BITS) * MAX_WAYS;
   localparam int RANK_TOP     = MAX_WAYS - 1;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 10;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_item_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_item_type          rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Cache image kept by the predictor
   logic                  line_valid [LINE_COUNT];
   logic [TAG_W-1:0]      line_tag   [LINE_COUNT];
   logic [2:0]            line_rank  [LINE_COUNT];
   logic [COUNT_W-1:0]    hit_total;
   logic [COUNT_W-1:0]    miss_total;
   logic [COUNT_W-1:0]    eviction_total;
   logic [2:0]            cfg_set_bits;
   logic [3:0]            cfg_ways;
   logic [4:0]            cfg_block_bits;

   rsp_item_type          pending_results [$];
   int                    error_count = 0;
   int                    result_count = 0;
   int                    cycle_count = 0;
   bit                    idle_on = 1'b1;

   set_assoc_cache_lru_sim_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL set_assoc_cache_lru_sim_core");
         $finish;
      end
   end

   function automatic logic [COUNT_W-1:0] sat_add(logic [COUNT_W-1:0] a, int unsigned b);
      logic [COUNT_W:0] sum;
      sum = {1'b0, a} + b;
      return sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
   endfunction

   function automatic int unsigned eff_set_bits();
      return (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : cfg_set_bits;
   endfunction

   function automatic int unsigned eff_ways();
      if (cfg_ways == 0) return 1;
      return (cfg_ways > MAX_WAYS) ? MAX_WAYS : cfg_ways;
   endfunction

   task automatic clear_cache_image();
      for (int i = 0; i < LINE_COUNT; i++) begin
         line_valid[i] = 1'b0;
         line_tag[i]   = '0;
         line_rank[i]  = '0;
      end
      hit_total      = '0;
      miss_total     = '0;
      eviction_total = '0;
      cfg_set_bits   = 3'd0;
      cfg_ways       = 4'd1;
      cfg_block_bits = 5'd0;
   endtask

   // One access against the cache image: lookup, fill or LRU victim, rank update
   function automatic rsp_item_type access_cache(logic [KIND_W-1:0] kind,
                                                 logic [ADDR_W-1:0] addr);
      int unsigned  sb, nw, set_idx, base, victim, empty_ln, ln;
      logic [31:0]  shifted, tag;
      logic         hit, found_empty, evict;
      logic [2:0]   old_rank;
      int unsigned  hits;
      rsp_item_type r;
      sb          = eff_set_bits();
      nw          = eff_ways();
      shifted     = addr >> cfg_block_bits;
      set_idx     = (sb == 0) ? 0 : (shifted & ((32'd1 << sb) - 1));
      tag         = shifted >> sb;
      base        = set_idx * MAX_WAYS;
      victim      = base;
      empty_ln    = 0;
      hit         = 1'b0;
      found_empty = 1'b0;
      evict       = 1'b0;
      old_rank    = '0;
      for (int i = 0; i < nw; i++) begin
         ln = base + i;
         if (!hit) begin
            if (line_valid[ln] && line_tag[ln] == tag) begin
               hit    = 1'b1;
               victim = ln;
            end else if (!line_valid[ln] && !found_empty) begin
               found_empty = 1'b1;
               empty_ln    = ln;
            end
         end
      end
      if (hit) begin
         old_rank = line_rank[victim];
      end else if (found_empty) begin
         victim = empty_ln;
      end else begin
         // first used line with the greatest rank
         victim = base;
         for (int i = 1; i < nw; i++)
            if (line_rank[base + i] > line_rank[victim]) victim = base + i;
         evict = 1'b1;
      end
      // age the other valid lines
      for (int i = 0; i < nw; i++) begin
         ln = base + i;
         if (ln != victim && line_valid[ln] && !(hit && line_rank[ln] >= old_rank))
            if (line_rank[ln] < RANK_TOP) line_rank[ln] = line_rank[ln] + 3'd1;
      end
      line_rank[victim]  = '0;
      line_valid[victim] = 1'b1;
      line_tag[victim]   = tag;

      hits = (hit ? 1 : 0) + ((kind == KIND_MODIFY) ? 1 : 0);
      hit_total = sat_add(hit_total, hits);
      if (!hit) miss_total = sat_add(miss_total, 1);
      if (evict) eviction_total = sat_add(eviction_total, 1);

      r.hit_count       = hits[1:0];
      r.missed          = !hit;
      r.evicted         = evict;
      r.total_hits      = hit_total;
      r.total_misses    = miss_total;
      r.total_evictions = eviction_total;
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("result %0d: %s is %0h, expected %0h", result_count, field, got, want);
      error_count++;
   endtask

   // Send one access item; valid is lowered only by the next call or by hold_requests
   task automatic send_access(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr);
      int gap;
      gap = idle_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data.req_type <= kind;
      req_data.address  <= addr;
      do @(posedge clock); while (!(req_valid && req_ready));
      pending_results.push_back(access_cache(kind, addr));
   endtask

   task automatic hold_requests();
      req_valid <= 1'b0;
   endtask

   // Register write once every result is out and the pipeline has drained
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int unsigned value);
      hold_requests();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SET_BITS:    cfg_set_bits   = value[2:0];
         CSR_WAYS_IN_USE: cfg_ways       = value[3:0];
         CSR_BLOCK_BITS:  cfg_block_bits = value[4:0];
         default: ;
      endcase
   endtask

   task automatic configure(int unsigned sb, int unsigned ways, int unsigned bb);
      write_csr(CSR_SET_BITS, sb);
      write_csr(CSR_WAYS_IN_USE, ways);
      write_csr(CSR_BLOCK_BITS, bb);
   endtask

   // Result side: random stall per item, then compare with the oldest prediction
   initial begin
      rsp_item_type want;
      int stall;
      wait (!reset);
      forever begin
         stall = idle_on ? $urandom_range(0, 6) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         result_count++;
         if (pending_results.size() == 0) begin
            $display("result %0d: no access outstanding", result_count);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.hit_count !== want.hit_count)
               report_mismatch("hit_count", 32'(rsp_data.hit_count), 32'(want.hit_count));
            if (rsp_data.missed !== want.missed)
               report_mismatch("missed", 32'(rsp_data.missed), 32'(want.missed));
            if (rsp_data.evicted !== want.evicted)
               report_mismatch("evicted", 32'(rsp_data.evicted), 32'(want.evicted));
            if (rsp_data.total_hits !== want.total_hits)
               report_mismatch("total_hits", rsp_data.total_hits, want.total_hits);
            if (rsp_data.total_misses !== want.total_misses)
               report_mismatch("total_misses", rsp_data.total_misses, want.total_misses);
            if (rsp_data.total_evictions !== want.total_evictions)
               report_mismatch("total_evictions", rsp_data.total_evictions,
                               want.total_evictions);
         end
      end
   end

   // Geometry out of reset: one set, one way, no offset
   task automatic test_reset_geometry();
      send_access(KIND_LOAD, 32'h0);
      send_access(KIND_LOAD, 32'h0);
      send_access(KIND_MODIFY, 32'h0);
      send_access(KIND_STORE, 32'h1);
      send_access(KIND_UNUSED, 32'h1);
      send_access(KIND_MODIFY, 32'hFFFF_FFFF);
   endtask

   // Fill one set, refresh a line, then check the LRU victims
   task automatic test_lru_order();
      configure(2, 4, 4);
      for (int t = 1; t <= 4; t++) send_access(KIND_LOAD, 32'(t) << 6);
      send_access(KIND_STORE, 32'h1 << 6);
      send_access(KIND_LOAD, 32'h5 << 6);
      send_access(KIND_MODIFY, 32'h2 << 6);
   endtask

   // Field values past the usable range: clamped set bits and ways, widest offset
   task automatic test_oversized_fields();
      configure(7, 15, 31);
      send_access(KIND_LOAD, 32'hFFFF_FFFF);
      send_access(KIND_LOAD, 32'h7FFF_FFFF);
      send_access(KIND_MODIFY, 32'h8000_0000);
      send_access(KIND_STORE, 32'h0);
   endtask

   // Lines survive a change of ways; zero ways acts as one
   task automatic test_ways_change();
      configure(0, 3, 2);
      for (int t = 0; t < 3; t++) send_access(KIND_LOAD, 32'(t) << 2);
      write_csr(CSR_WAYS_IN_USE, 0);
      send_access(KIND_LOAD, 32'h2 << 2);
      write_csr(CSR_WAYS_IN_USE, 8);
      send_access(KIND_LOAD, 32'h1 << 2);
   endtask

   // Phases of random geometry; most accesses reuse a small tag and set pool
   task automatic test_random_traffic(int phases, int per_phase);
      int unsigned sb, nw, bb, tag_span, set_span, nsets;
      logic [31:0] tag_hi, tag, off_mask, off;
      logic [63:0] wide;
      int unsigned set_idx;
      for (int p = 0; p < phases; p++) begin
         case (p)
            0: configure(6, 8, 0);
            1: configure(0, 1, 26);
            2: configure(7, 0, 31);
            default: configure($urandom_range(0, 7), $urandom_range(0, 15),
                               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                           : $urandom_range(0, 8));
         endcase
         sb       = eff_set_bits();
         nw       = eff_ways();
         bb       = cfg_block_bits;
         nsets    = 1 << sb;
         tag_span = nw + $urandom_range(0, 4);
         set_span = $urandom_range(1, 4);
         if (set_span > nsets) set_span = nsets;
         tag_hi   = $urandom;
         off_mask = (32'd1 << bb) - 1;
         for (int n = 0; n < per_phase; n++) begin
            if (n % 30 == 0) idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 8) begin
               tag     = tag_hi ^ $urandom_range(0, tag_span);
               set_idx = $urandom_range(0, set_span - 1);
               off     = $urandom & off_mask;
               wide    = (64'(tag) << (sb + bb)) | (64'(set_idx) << bb) | 64'(off);
               send_access(KIND_W'($urandom_range(0, 3)), wide[31:0]);
            end else begin
               send_access(KIND_W'($urandom_range(0, 3)), $urandom);
            end
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin
      clear_cache_image();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_geometry();
      test_lru_order();
      test_oversized_fields();
      test_ways_change();
      test_random_traffic(10, 93);
      hold_requests();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS set_assoc_cache_lru_sim_core");
      end else begin
         $display("FAIL set_assoc_cache_lru_sim_core");
      end
      $finish;
   end

endmodule
